@@ hw/rtl/pal_pkg.sv @@
// Shared types and constants for the positional array list.
`default_nettype none

package pal_pkg;

    // List storage
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_SEARCH,
        S_DUMP_RD,
        S_DUMP_WAIT,
        S_RESP
    } state_t;

    // One result transaction
    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  index;
        logic [WORD_W-1:0]   entry_value;
        logic                last;
    } result_t;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic                busy;
        logic [COUNT_W-1:0]  count;
    } seq_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/pal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [WIDTH-1:0]          wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pal_seq.sv @@
// Sequencer: walks the entry RAM for insert, delete, search and dump.
`default_nettype none

module pal_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire pal_pkg::op_t                  cmd_op,
    input  wire logic [pal_pkg::POS_W-1:0]     cmd_pos,
    input  wire logic [pal_pkg::WORD_W-1:0]    cmd_value,
    // result toward the output register
    output logic                               res_valid,
    output pal_pkg::result_t                   res,
    input  wire logic                          res_free,
    // RAM
    output logic                               ram_wr_en,
    output logic [pal_pkg::ADDR_W-1:0]         ram_wr_addr,
    output logic [pal_pkg::WORD_W-1:0]         ram_wr_data,
    output logic                               ram_rd_en,
    output logic [pal_pkg::ADDR_W-1:0]         ram_rd_addr,
    input  wire logic [pal_pkg::WORD_W-1:0]    ram_rd_data,
    // status
    output pal_pkg::seq_stat_t                 stat
);

    localparam int CW = pal_pkg::COUNT_W;
    localparam int AW = pal_pkg::ADDR_W;
    localparam int PW = pal_pkg::POS_W;

    pal_pkg::state_t             state_reg, state_next;
    pal_pkg::op_t                op_reg, op_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic [pal_pkg::WORD_W-1:0]  value_reg, value_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic                        wr_pend_reg, wr_pend_next;
    logic [AW-1:0]               wr_addr_reg, wr_addr_next;
    logic                        cmp_pend_reg, cmp_pend_next;
    logic [AW-1:0]               cmp_idx_reg, cmp_idx_next;
    pal_pkg::result_t            res_reg, res_next;

    logic                        more;
    logic                        dump_last;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pal_pkg::S_IDLE;
            count_reg    <= '0;
            wr_pend_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wr_pend_reg  <= wr_pend_next;
            cmp_pend_reg <= cmp_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    // Shift direction test: insert walks down to pos, delete walks up to count
    assign more = (op_reg == pal_pkg::OP_INSERT) ? (PW'(ptr_reg) > pos_reg)
                                                  : (ptr_reg < count_reg);
    assign dump_last = (ptr_reg == count_reg);

    // Next state and outputs
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        wr_pend_next  = wr_pend_reg;
        wr_addr_next  = wr_addr_reg;
        cmp_pend_next = cmp_pend_reg;
        cmp_idx_next  = cmp_idx_reg;
        res_next      = res_reg;

        cmd_ready   = 1'b0;
        res_valid   = 1'b0;
        res         = res_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg[AW-1:0];

        unique case (state_reg)
            pal_pkg::S_IDLE: begin
                cmd_ready = 1'b1;
                res_next  = '{status: pal_pkg::ST_OK, index: '0, entry_value: '0, last: 1'b1};
                if (cmd_valid) begin
                    op_next       = cmd_op;
                    pos_next      = cmd_pos;
                    value_next    = cmd_value;
                    wr_pend_next  = 1'b0;
                    cmp_pend_next = 1'b0;
                    unique case (cmd_op)
                        pal_pkg::OP_INSERT: begin
                            if (count_reg == CW'(pal_pkg::CAPACITY)) begin
                                res_next.status = pal_pkg::ST_FULL;
                                state_next      = pal_pkg::S_RESP;
                            end else if (cmd_pos > PW'(count_reg)) begin
                                res_next.status = pal_pkg::ST_BADPOS;
                                state_next      = pal_pkg::S_RESP;
                            end else begin
                                ptr_next   = count_reg;
                                state_next = pal_pkg::S_SHIFT;
                            end
                        end
                        pal_pkg::OP_DELETE: begin
                            if (count_reg == '0) begin
                                res_next.status = pal_pkg::ST_EMPTY;
                                state_next      = pal_pkg::S_RESP;
                            end else if (cmd_pos >= PW'(count_reg)) begin
                                res_next.status = pal_pkg::ST_BADPOS;
                                state_next      = pal_pkg::S_RESP;
                            end else begin
                                ptr_next   = CW'(cmd_pos) + CW'(1);
                                state_next = pal_pkg::S_SHIFT;
                            end
                        end
                        pal_pkg::OP_SEARCH: begin
                            if (count_reg == '0) begin
                                res_next.status = pal_pkg::ST_EMPTY;
                                state_next      = pal_pkg::S_RESP;
                            end else begin
                                ptr_next   = '0;
                                state_next = pal_pkg::S_SEARCH;
                            end
                        end
                        pal_pkg::OP_DUMP: begin
                            if (count_reg == '0) begin
                                res_next.status = pal_pkg::ST_EMPTY;
                                state_next      = pal_pkg::S_RESP;
                            end else begin
                                ptr_next   = '0;
                                state_next = pal_pkg::S_DUMP_RD;
                            end
                        end
                    endcase
                end
            end

            // Move one entry per cycle: read one slot, write it to its neighbor next cycle
            pal_pkg::S_SHIFT: begin
                ram_wr_en = wr_pend_reg;
                if (more) begin
                    ram_rd_en    = 1'b1;
                    wr_pend_next = 1'b1;
                    if (op_reg == pal_pkg::OP_INSERT) begin
                        ram_rd_addr  = AW'(ptr_reg - CW'(1));
                        wr_addr_next = ptr_reg[AW-1:0];
                        ptr_next     = ptr_reg - CW'(1);
                    end else begin
                        ram_rd_addr  = ptr_reg[AW-1:0];
                        wr_addr_next = AW'(ptr_reg - CW'(1));
                        ptr_next     = ptr_reg + CW'(1);
                    end
                end else begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg) begin
                        if (op_reg == pal_pkg::OP_INSERT) begin
                            state_next = pal_pkg::S_PUT;
                        end else begin
                            count_next = count_reg - CW'(1);
                            state_next = pal_pkg::S_RESP;
                        end
                    end
                end
            end

            // Insert: drop the new word into the opened slot
            pal_pkg::S_PUT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg[AW-1:0];
                ram_wr_data = value_reg;
                count_next  = count_reg + CW'(1);
                state_next  = pal_pkg::S_RESP;
            end

            // Search: read ahead one entry while comparing the previous one
            pal_pkg::S_SEARCH: begin
                if (cmp_pend_reg && (ram_rd_data == value_reg)) begin
                    res_next.index = pal_pkg::INDEX_W'(cmp_idx_reg);
                    cmp_pend_next  = 1'b0;
                    state_next     = pal_pkg::S_RESP;
                end else if (ptr_reg < count_reg) begin
                    ram_rd_en     = 1'b1;
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end else if (cmp_pend_reg) begin
                    cmp_pend_next = 1'b0;
                end else begin
                    res_next.status = pal_pkg::ST_NOTFOUND;
                    state_next      = pal_pkg::S_RESP;
                end
            end

            // Dump: fetch one entry
            pal_pkg::S_DUMP_RD: begin
                ram_rd_en    = 1'b1;
                cmp_idx_next = ptr_reg[AW-1:0];
                ptr_next     = ptr_reg + CW'(1);
                state_next   = pal_pkg::S_DUMP_WAIT;
            end

            // Dump: hand the fetched entry to the output register
            pal_pkg::S_DUMP_WAIT: begin
                res_valid       = 1'b1;
                res.status      = pal_pkg::ST_OK;
                res.index       = pal_pkg::INDEX_W'(cmp_idx_reg);
                res.entry_value = ram_rd_data;
                res.last        = dump_last;
                if (res_free) begin
                    state_next = dump_last ? pal_pkg::S_IDLE : pal_pkg::S_DUMP_RD;
                end
            end

            // Single result
            pal_pkg::S_RESP: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = pal_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pal_pkg::S_IDLE;
            end
        endcase
    end

    assign stat.busy  = (state_reg != pal_pkg::S_IDLE);
    assign stat.count = count_reg;

endmodule

`default_nettype wire

@@ hw/rtl/positional_array_list.sv @@
// Top level of the positional array list: sequencer, entry RAM, output register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | operation, position, value
//  m_      | out       | m_valid / m_ready  | status, index, entry_value, last
//
// An operation is accepted only when the sequencer is idle; one transaction at a time.
// An insert or delete moves every entry between the position and the tail, a search reads
// entries until a hit or the end of the list, a dump reads every entry, and errors and empty
// lists go straight to the result. A stalled m_ready holds the sequencer only when a new
// result is ready.
// Reset (aresetn, synchronous) empties the list; the RAM itself is never cleared.
`default_nettype none

module positional_array_list (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_operation,
    input  wire logic [6:0]          s_position,
    input  wire logic signed [31:0]  s_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_status,
    output logic [5:0]               m_index,
    output logic signed [31:0]       m_entry_value,
    output logic                     m_last
);

    logic                             res_valid;
    pal_pkg::result_t                 res;
    logic                             res_free;
    pal_pkg::seq_stat_t               stat;

    logic                             ram_wr_en;
    logic [pal_pkg::ADDR_W-1:0]       ram_wr_addr;
    logic [pal_pkg::WORD_W-1:0]       ram_wr_data;
    logic                             ram_rd_en;
    logic [pal_pkg::ADDR_W-1:0]       ram_rd_addr;
    logic [pal_pkg::WORD_W-1:0]       ram_rd_data;

    logic                             m_valid_reg;
    pal_pkg::result_t                 out_reg;

    pal_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (s_valid),
        .cmd_ready   (s_ready),
        .cmd_op      (pal_pkg::op_t'(s_operation)),
        .cmd_pos     (s_position),
        .cmd_value   (s_value),
        .res_valid   (res_valid),
        .res         (res),
        .res_free    (res_free),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .stat        (stat)
    );

    pal_ram #(
        .WIDTH (pal_pkg::WORD_W),
        .DEPTH (pal_pkg::CAPACITY)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: free when empty or being taken this cycle
    assign res_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_index       = out_reg.index;
    assign m_entry_value = out_reg.entry_value;
    assign m_last        = out_reg.last;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= pal_pkg::COUNT_W'(pal_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && stat.busy)
        else $error("accepted a transaction while still working");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pal_pkg::ST_OK) |-> m_last)
        else $error("error result not marked last");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.count != $past(stat.count)) |->
            (stat.count == $past(stat.count) + pal_pkg::COUNT_W'(1)) ||
            (stat.count == $past(stat.count) - pal_pkg::COUNT_W'(1)))
        else $error("entry count moved by more than one");

endmodule

`default_nettype wire
